[rtl/cpfa_pkg.sv]
// ============================================================================
// cpfa_pkg
// Shared types and constants of the contiguous page-frame allocator.
// ============================================================================
package cpfa_pkg;

    // Field widths
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned LEN_W    = 13;
    localparam int unsigned VADDR_W  = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned PHYS_W   = 24;
    localparam int unsigned USED_W   = 13;
    localparam int unsigned CFG_IDX_W = 2;

    // Map entry: free flag on top, stored run length below
    localparam int unsigned ENTRY_W  = LEN_W + 1;

    // Parameter defaults
    localparam int unsigned MAX_PAGES_DEF  = 4096;
    localparam int unsigned PAGE_BYTES_DEF = 4096;

    // Base of the kernel direct-mapped segment
    localparam logic [VADDR_W-1:0] KSEG_BASE = 32'h8000_0000;

    // Configuration register reset values
    localparam logic [CFG_W-1:0] TOTAL_RST  = 13'd4096;
    localparam logic [CFG_W-1:0] KERNEL_RST = 13'd0;
    localparam logic [CFG_W-1:0] MAP_RST    = 13'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL  = 2'd0,
        CFG_KERNEL = 2'd1,
        CFG_MAP    = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE,
        S_DONE
    } t_state;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD_INIT,
        CMD_INIT_STEP,
        CMD_LOAD_ALLOC,
        CMD_SCAN_STEP,
        CMD_MARK_STEP,
        CMD_LOAD_FREE,
        CMD_FREE_SETUP,
        CMD_FREE_STEP,
        CMD_SET_OK,
        CMD_SET_NOSPACE,
        CMD_SET_BAD,
        CMD_PUBLISH
    } t_dp_cmd;

    // Datapath status back to the controller
    typedef struct packed {
        logic init_end;
        logic scan_none;
        logic scan_hit;
        logic scan_miss;
        logic mark_last;
        logic free_range_bad;
        logic free_already;
        logic free_last;
    } t_dp_stat;

endpackage

[rtl/contiguous_page_frame_allocator.sv]
// ============================================================================
// contiguous_page_frame_allocator
// First-fit contiguous page-frame allocator over a map of up to MAX_PAGES
// frames, each frame holding a free flag and the length of its run.
// ============================================================================
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  ---------------------------------
//  input     in         i_valid / o_stall    i_operation i_run_length i_address
//  output    out        o_valid / i_stall    o_status o_phys_address
//                                            o_used_pages
//  config    in         i_cfg_we             i_cfg_index i_cfg_data
//
//  The frame map has one read and one write port and is walked one entry per
//  cycle. Initialize writes every map entry, allocate scans up to the whole
//  map and then marks run_length entries, free releases the stored run of the
//  addressed frame, and a bad request ends without a walk.
//  Reset is synchronous and clears control state only; the map contents are
//  read only after an initialize has rewritten them, so no clearing pass runs.
//  One transaction is in work at a time; a finished result waits in the output
//  register under i_stall while the next transaction is taken.
// ============================================================================
module contiguous_page_frame_allocator
    import cpfa_pkg::*;
#(
    parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
    parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [LEN_W-1:0]     i_run_length,
    input  logic [VADDR_W-1:0]   i_address,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [PHYS_W-1:0]    o_phys_address,
    output logic [USED_W-1:0]    o_used_pages
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    cpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    // Frame map and arithmetic
    cpfa_dpath #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_run_length   (i_run_length),
        .i_address      (i_address),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_status       (o_status),
        .o_phys_address (o_phys_address),
        .o_used_pages   (o_used_pages)
    );

endmodule

[rtl/cpfa_ram.sv]
// ============================================================================
// cpfa_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module cpfa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/cpfa_dpath.sv]
// ============================================================================
// cpfa_dpath
// Frame map, scan and free pointers, counters, configuration and result
// registers of the page-frame allocator.
// ============================================================================
module cpfa_dpath
    import cpfa_pkg::*;
#(
    parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
    parameter int unsigned PAGE_BYTES = PAGE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // transaction payload
    input  logic [LEN_W-1:0]     i_run_length,
    input  logic [VADDR_W-1:0]   i_address,
    // controller link
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    // result payload
    output logic [STAT_W-1:0]    o_status,
    output logic [PHYS_W-1:0]    o_phys_address,
    output logic [USED_W-1:0]    o_used_pages
);

    localparam int unsigned IDX_W      = $clog2(MAX_PAGES);
    localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Configuration registers
    logic [CFG_W-1:0]   r_total, r_kernel, r_map;

    // Map control state
    logic [CNT_W-1:0]   r_map_size, n_map_size;
    logic [USED_W-1:0]  r_used, n_used;
    logic               r_pend, n_pend;
    logic               r_bad, n_bad;

    // Working registers
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic [CNT_W-1:0]   r_chk, n_chk;
    logic [CNT_W-1:0]   r_end, n_end;
    logic [LEN_W-1:0]   r_run_len, n_run_len;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [STAT_W-1:0]  r_status, n_status;
    logic [PHYS_W-1:0]  r_phys, n_phys;

    // Result registers
    logic [STAT_W-1:0]  r_out_status;
    logic [PHYS_W-1:0]  r_out_phys;
    logic [USED_W-1:0]  r_out_used;

    // Map memory ports
    logic                 wr_en;
    logic [CNT_W-1:0]     wr_addr_full;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ENTRY_W-1:0]   rd_data;
    logic                 rd_free;
    logic [LEN_W-1:0]     rd_len;

    // Derived values
    logic [CFG_W-1:0]     map_eff;
    logic [31:0]          res_sum;
    logic [31:0]          new_map_size;
    logic [31:0]          new_used;
    logic [VADDR_W-1:0]   free_off;
    logic [31:0]          free_idx;
    logic [31:0]          scan_start;
    logic [63:0]          scan_phys;
    logic [31:0]          free_end;

    cpfa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PAGES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr_full[IDX_W-1:0]),
        .i_wdata (wr_data),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    assign rd_free = rd_data[ENTRY_W-1];
    assign rd_len  = rd_data[LEN_W-1:0];

    // Decode reserved runs, the frame index of a free request and the scan and free bounds
    always_comb begin
        map_eff      = (r_map == '0) ? CFG_W'(1) : r_map;
        res_sum      = 32'(r_kernel) + 32'(map_eff);
        new_map_size = (32'(r_total) < MAX_PAGES) ? 32'(r_total) : MAX_PAGES;
        new_used     = (res_sum < new_map_size) ? res_sum : new_map_size;
        free_off     = i_address - KSEG_BASE;
        free_idx     = 32'(free_off >> PAGE_SHIFT);
        scan_start   = 32'(r_chk) + 32'd1 - 32'(r_run_len);
        scan_phys    = 64'(scan_start) << PAGE_SHIFT;
        free_end     = ((32'(r_addr) + 32'(rd_len)) < 32'(r_map_size))
                     ? (32'(r_addr) + 32'(rd_len)) : 32'(r_map_size);
    end

    // Status toward the controller
    always_comb begin
        o_stat                = '0;
        o_stat.init_end       = (r_addr >= r_map_size);
        o_stat.scan_none      = (r_run_len == '0) || (r_map_size == '0);
        o_stat.scan_hit       = r_pend && rd_free && ((r_count + LEN_W'(1)) == r_run_len);
        o_stat.scan_miss      = r_pend && !o_stat.scan_hit
                              && ((32'(r_chk) + 32'd1) >= 32'(r_map_size));
        o_stat.mark_last      = (r_addr == r_chk);
        o_stat.free_range_bad = r_bad;
        o_stat.free_already   = rd_free;
        o_stat.free_last      = r_pend && ((32'(r_chk) + 32'd1) >= 32'(r_end));
    end

    // Next-state logic of the working registers and map writes
    always_comb begin
        n_map_size   = r_map_size;
        n_used       = r_used;
        n_pend       = r_pend;
        n_bad        = r_bad;
        n_addr       = r_addr;
        n_chk        = r_chk;
        n_end        = r_end;
        n_run_len    = r_run_len;
        n_count      = r_count;
        n_status     = r_status;
        n_phys       = r_phys;
        wr_en        = 1'b0;
        wr_addr_full = r_addr;
        wr_data      = '0;
        unique case (i_cmd)
            CMD_LOAD_INIT: begin
                n_map_size = CNT_W'(new_map_size);
                n_used     = USED_W'(new_used);
                n_addr     = '0;
                n_status   = ST_OK;
                n_phys     = '0;
            end
            CMD_INIT_STEP: begin
                // Kernel run, then map run, then free frames
                wr_en = 1'b1;
                if (32'(r_addr) < 32'(r_kernel)) begin
                    wr_data = {1'b0, r_kernel};
                end else if (32'(r_addr) < res_sum) begin
                    wr_data = {1'b0, map_eff};
                end else begin
                    wr_data = {1'b1, LEN_W'(0)};
                end
                n_addr = r_addr + CNT_W'(1);
            end
            CMD_LOAD_ALLOC: begin
                n_run_len = i_run_length;
                n_addr    = '0;
                n_pend    = 1'b0;
                n_count   = '0;
                n_status  = ST_OK;
                n_phys    = '0;
            end
            CMD_SCAN_STEP: begin
                if (o_stat.scan_hit) begin
                    // Found: rewind to the run start and keep the end in r_chk
                    n_addr = CNT_W'(scan_start);
                    n_phys = scan_phys[PHYS_W-1:0];
                    n_used = r_used + r_run_len;
                    n_pend = 1'b0;
                end else begin
                    if (r_pend) begin
                        n_count = rd_free ? (r_count + LEN_W'(1)) : '0;
                    end
                    n_chk  = r_addr;
                    n_addr = r_addr + CNT_W'(1);
                    n_pend = 1'b1;
                end
            end
            CMD_MARK_STEP: begin
                wr_en   = 1'b1;
                wr_data = {1'b0, r_run_len};
                n_addr  = r_addr + CNT_W'(1);
            end
            CMD_LOAD_FREE: begin
                n_bad    = (free_idx >= 32'(r_map_size));
                n_addr   = CNT_W'(free_idx);
                n_status = ST_OK;
                n_phys   = '0;
            end
            CMD_FREE_SETUP: begin
                n_end  = CNT_W'(free_end);
                n_pend = 1'b0;
            end
            CMD_FREE_STEP: begin
                // Release the checked frame, count it only if it was in use
                if (r_pend && (r_chk < r_end)) begin
                    wr_en        = 1'b1;
                    wr_addr_full = r_chk;
                    wr_data      = {1'b1, LEN_W'(0)};
                    if (!rd_free && (r_used != '0)) begin
                        n_used = r_used - USED_W'(1);
                    end
                end
                n_chk  = r_addr;
                n_addr = r_addr + CNT_W'(1);
                n_pend = 1'b1;
            end
            CMD_SET_OK: begin
                n_status = ST_OK;
                n_phys   = '0;
            end
            CMD_SET_NOSPACE: begin
                n_status = ST_NO_SPACE;
                n_phys   = '0;
            end
            CMD_SET_BAD: begin
                n_status = ST_BAD_FREE;
                n_phys   = '0;
            end
            CMD_PUBLISH, CMD_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= TOTAL_RST;
            r_kernel   <= KERNEL_RST;
            r_map      <= MAP_RST;
            r_map_size <= '0;
            r_used     <= '0;
            r_pend     <= 1'b0;
            r_bad      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TOTAL:  r_total  <= i_cfg_data;
                    CFG_KERNEL: r_kernel <= i_cfg_data;
                    CFG_MAP:    r_map    <= i_cfg_data;
                    CFG_NONE:   ;
                    default:    ;
                endcase
            end
            r_map_size <= n_map_size;
            r_used     <= n_used;
            r_pend     <= n_pend;
            r_bad      <= n_bad;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_chk     <= n_chk;
        r_end     <= n_end;
        r_run_len <= n_run_len;
        r_count   <= n_count;
        r_status  <= n_status;
        r_phys    <= n_phys;
        if (i_cmd == CMD_PUBLISH) begin
            r_out_status <= r_status;
            r_out_phys   <= r_phys;
            r_out_used   <= r_used;
        end
    end

    assign o_status       = r_out_status;
    assign o_phys_address = r_out_phys;
    assign o_used_pages   = r_out_used;

    // The scan only reads the map
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_SCAN_STEP) |-> !wr_en)
        else $error("map written during scan");

    // Every map write lands inside the initialized map
    a_write_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (wr_addr_full < r_map_size))
        else $error("map write beyond map size");

    // Used count never exceeds the map size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(r_map_size))
        else $error("used count above map size");

endmodule

[rtl/cpfa_ctrl.sv]
// ============================================================================
// cpfa_ctrl
// Sequencer of the page-frame allocator: takes one transaction at a time,
// steps the datapath through init, scan, mark and free, and owns the
// result valid flag.
// ============================================================================
module cpfa_ctrl
    import cpfa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input channel handshake
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [OP_W-1:0] i_operation,
    // output channel handshake
    output logic            o_valid,
    input  logic            i_stall,
    // datapath link
    output t_dp_cmd         o_cmd,
    input  t_dp_stat        i_stat
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_acc;
    logic   out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_acc  = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_INIT:  n_state = S_INIT;
                        OP_ALLOC: n_state = S_SCAN;
                        OP_FREE:  n_state = S_FREE_RD;
                        OP_NOP:   n_state = S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                if (i_stat.init_end) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                priority if (i_stat.scan_none) begin
                    n_state = S_DONE;
                end else if (i_stat.scan_hit) begin
                    n_state = S_MARK;
                end else if (i_stat.scan_miss) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_MARK: begin
                if (i_stat.mark_last) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_RD: begin
                n_state = i_stat.free_range_bad ? S_DONE : S_FREE_CHK;
            end
            S_FREE_CHK: begin
                n_state = i_stat.free_already ? S_DONE : S_FREE;
            end
            S_FREE: begin
                if (i_stat.free_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_INIT:  o_cmd = CMD_LOAD_INIT;
                        OP_ALLOC: o_cmd = CMD_LOAD_ALLOC;
                        OP_FREE:  o_cmd = CMD_LOAD_FREE;
                        OP_NOP:   o_cmd = CMD_SET_OK;
                        default:  o_cmd = CMD_SET_OK;
                    endcase
                end
            end
            S_INIT: begin
                if (!i_stat.init_end) begin
                    o_cmd = CMD_INIT_STEP;
                end
            end
            S_SCAN: begin
                priority if (i_stat.scan_none) begin
                    o_cmd = CMD_SET_NOSPACE;
                end else if (i_stat.scan_hit) begin
                    o_cmd = CMD_SCAN_STEP;
                end else if (i_stat.scan_miss) begin
                    o_cmd = CMD_SET_NOSPACE;
                end else begin
                    o_cmd = CMD_SCAN_STEP;
                end
            end
            S_MARK:     o_cmd = CMD_MARK_STEP;
            S_FREE_RD: begin
                if (i_stat.free_range_bad) begin
                    o_cmd = CMD_SET_BAD;
                end
            end
            S_FREE_CHK: o_cmd = i_stat.free_already ? CMD_SET_BAD : CMD_FREE_SETUP;
            S_FREE:     o_cmd = CMD_FREE_STEP;
            S_DONE: begin
                if (out_free) begin
                    o_cmd = CMD_PUBLISH;
                end
            end
            default:    o_cmd = CMD_NONE;
        endcase
    end

    // Result valid: set on publish, drop when the transaction is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd == CMD_PUBLISH) begin
            n_out_valid = 1'b1;
        end else if (out_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    // A result is published only into a free or draining output register
    a_publish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_PUBLISH) |-> (!r_out_valid || !i_stall))
        else $error("result published over a pending one");

    // Publishing always raises valid at the next edge
    a_publish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_PUBLISH) |=> o_valid)
        else $error("published result not shown");

    // A publish ends the transaction
    a_publish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == CMD_PUBLISH) |=> (r_state == S_IDLE))
        else $error("sequencer busy after publish");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page-frame allocator testbench
// Drives initialize, allocate and free transactions into the allocator under
// random source gaps and sink stalls. A frame-map model in the bench predicts
// status, physical address and used-frame count for every transaction, and
// the monitor compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import cpfa_pkg::*;

    localparam int unsigned MAX_PAGES     = MAX_PAGES_DEF;
    localparam int unsigned PAGE_BYTES    = PAGE_BYTES_DEF;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 4_000_000;

    typedef struct packed {
        t_op                op;
        logic [LEN_W-1:0]   len;
        logic [VADDR_W-1:0] vaddr;
    } page_req_t;

    typedef struct packed {
        t_status            status;
        logic [PHYS_W-1:0]  phys;
        logic [USED_W-1:0]  used;
    } page_result_t;

    // DUT ports
    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_valid      = 1'b0;
    logic                 o_stall;
    logic [OP_W-1:0]      i_operation  = '0;
    logic [LEN_W-1:0]     i_run_length = '0;
    logic [VADDR_W-1:0]   i_address    = '0;
    logic                 o_valid;
    logic                 i_stall      = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [PHYS_W-1:0]    o_phys_address;
    logic [USED_W-1:0]    o_used_pages;

    // Register shadows
    logic [CFG_W-1:0] cfg_total  = TOTAL_RST;
    logic [CFG_W-1:0] cfg_kernel = KERNEL_RST;
    logic [CFG_W-1:0] cfg_map    = MAP_RST;

    // Frame-map model
    bit               frame_is_free [MAX_PAGES];
    bit [LEN_W-1:0]   frame_run     [MAX_PAGES];
    logic [USED_W-1:0] frames_used  = '0;
    int unsigned      map_frames    = 0;

    page_req_t    pending_reqs[$];
    page_result_t expected_results[$];

    // Bench bookkeeping
    bit           offering      = 1'b0;
    bit           calm          = 1'b0;
    int unsigned  src_gap       = 0;
    int unsigned  sink_gap      = 0;
    int unsigned  sink_hold     = 0;
    bit           sink_stall    = 1'b0;
    int           hold_at       = -1;
    int           results_seen  = 0;
    int           reqs_sent     = 0;
    int           errors        = 0;
    int           settings_used = 0;
    int unsigned  cycle_count   = 0;
    page_req_t    drv_req;
    page_result_t drv_res;
    page_result_t mon_exp;

    contiguous_page_frame_allocator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_run_length   (i_run_length),
        .i_address      (i_address),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_phys_address (o_phys_address),
        .o_used_pages   (o_used_pages)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Update the frame map for one transaction and return its result
    task automatic apply_page_op(input logic [OP_W-1:0] op, input logic [LEN_W-1:0] n,
                                 input logic [VADDR_W-1:0] va, output page_result_t res);
        int unsigned i, k, m, run, start, idx, len;
        bit found;
        logic [VADDR_W-1:0] pa;
        res    = '{ST_OK, '0, '0};
        found  = 1'b0;
        run    = 0;
        start  = 0;
        case (op)
            OP_INIT: begin
                map_frames = (cfg_total < MAX_PAGES) ? cfg_total : MAX_PAGES;
                for (i = 0; i < MAX_PAGES; i++) begin
                    frame_is_free[i] = (i < map_frames);
                    frame_run[i]     = '0;
                end
                k = cfg_kernel;
                m = (cfg_map == 0) ? 1 : cfg_map;
                // Reserve kernel run, then map run, both clipped at the map end
                for (i = 0; i < k && i < map_frames; i++) begin
                    frame_is_free[i] = 1'b0;
                    frame_run[i]     = LEN_W'(k);
                end
                for (i = k; i < k + m && i < map_frames; i++) begin
                    frame_is_free[i] = 1'b0;
                    frame_run[i]     = LEN_W'(m);
                end
                frames_used = USED_W'((k + m < map_frames) ? k + m : map_frames);
            end
            OP_ALLOC: begin
                // First fit: lowest window of n free frames
                if (n != 0) begin
                    for (i = 0; i < map_frames && !found; i++) begin
                        if (frame_is_free[i]) begin
                            run++;
                            if (run == n) begin
                                start = i + 1 - n;
                                found = 1'b1;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
                if (found) begin
                    for (i = start; i < start + n; i++) begin
                        frame_is_free[i] = 1'b0;
                        frame_run[i]     = n;
                    end
                    frames_used = frames_used + USED_W'(n);
                    res.phys    = PHYS_W'(start * PAGE_BYTES);
                end else begin
                    res.status = ST_NO_SPACE;
                end
            end
            OP_FREE: begin
                pa  = va - KSEG_BASE;
                idx = pa / PAGE_BYTES;
                if (idx >= map_frames || frame_is_free[idx]) begin
                    res.status = ST_BAD_FREE;
                end else begin
                    len = frame_run[idx];
                    // Release the stored length from the addressed frame on
                    for (i = idx; i < idx + len && i < map_frames; i++) begin
                        if (!frame_is_free[i]) begin
                            frame_is_free[i] = 1'b1;
                            if (frames_used > 0) frames_used = frames_used - 1'b1;
                        end
                        frame_run[i] = '0;
                    end
                end
            end
            default: ;
        endcase
        res.used = frames_used;
    endtask

    // Source: present queued transactions, with random gaps after some of them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_page_op(i_operation, i_run_length, i_address, drv_res);
                expected_results.push_back(drv_res);
                reqs_sent++;
                offering = 1'b0;
                if (!calm && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 12);
            end
            if (!offering) begin
                if (src_gap != 0) begin
                    src_gap--;
                end else if (pending_reqs.size() != 0) begin
                    drv_req = pending_reqs.pop_front();
                    i_operation  <= drv_req.op;
                    i_run_length <= drv_req.len;
                    i_address    <= drv_req.vaddr;
                    offering = 1'b1;
                end
            end
            i_valid <= offering;
        end
    end

    // Sink: check each result, stall in random bursts and once for a long hold
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d phys %0h used %0d",
                             $time, o_status, o_phys_address, o_used_pages);
                    errors++;
                end else begin
                    mon_exp = expected_results.pop_front();
                    if (o_status !== mon_exp.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, mon_exp.status, o_status);
                        errors++;
                    end
                    if (o_phys_address !== mon_exp.phys) begin
                        $display("%0t: phys_address mismatch: expected %0h, actual %0h",
                                 $time, mon_exp.phys, o_phys_address);
                        errors++;
                    end
                    if (o_used_pages !== mon_exp.used) begin
                        $display("%0t: used_pages mismatch: expected %0d, actual %0d",
                                 $time, mon_exp.used, o_used_pages);
                        errors++;
                    end
                    results_seen++;
                    if (results_seen == hold_at) sink_hold = HOLD_CYCLES;
                end
            end
            if (sink_hold != 0) begin
                sink_hold--;
                sink_stall = 1'b1;
            end else if (sink_gap != 0) begin
                sink_gap--;
                sink_stall = 1'b1;
            end else begin
                sink_stall = 1'b0;
                if (!calm && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 12);
            end
            i_stall <= sink_stall;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [VADDR_W-1:0] frame_va(input int unsigned idx);
        return KSEG_BASE + VADDR_W'(idx * PAGE_BYTES);
    endfunction

    task automatic push_req(input t_op op, input logic [LEN_W-1:0] len,
                            input logic [VADDR_W-1:0] vaddr);
        pending_reqs.push_back('{op, len, vaddr});
    endtask

    // Random transaction: mostly sensible allocs and frees near the live map
    function automatic page_req_t random_req(input int unsigned frames);
        page_req_t   r;
        int unsigned pick, quarter;
        quarter = (frames > 4) ? frames / 4 : 1;
        r.op    = OP_ALLOC;
        r.len   = LEN_W'($urandom);
        r.vaddr = $urandom;
        pick    = $urandom_range(0, 99);
        if (pick < 4) begin
            r.len = '0;
        end else if (pick < 8) begin
            r.len = LEN_W'($urandom_range(frames, 8191));
        end else if (pick < 45) begin
            r.len = LEN_W'($urandom_range(1, quarter));
        end else if (pick < 85) begin
            r.op    = OP_FREE;
            r.vaddr = frame_va($urandom_range(0, frames)) + $urandom_range(0, PAGE_BYTES - 1);
        end else if (pick < 92) begin
            r.op = OP_FREE;
        end else if (pick < 96) begin
            r.op = OP_INIT;
        end else begin
            r.op = OP_NOP;
        end
        return r;
    endfunction

    // Drive one register write; the caller lowers the write enable afterwards
    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_TOTAL:  cfg_total  = val;
            CFG_KERNEL: cfg_kernel = val;
            CFG_MAP:    cfg_map    = val;
            default: ;
        endcase
    endtask

    task automatic configure(input int unsigned total, input int unsigned kernel,
                             input int unsigned mapn);
        write_cfg(CFG_TOTAL, CFG_W'(total));
        write_cfg(CFG_KERNEL, CFG_W'(kernel));
        write_cfg(CFG_MAP, CFG_W'(mapn));
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Wait until every transaction has been sent and answered, then a little more
    task automatic settle();
        while (pending_reqs.size() != 0 || offering || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned p, total;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: requests before any init, then a full 4096-frame map
        push_req(OP_ALLOC, 13'd1, '0);
        push_req(OP_FREE, '0, frame_va(0));
        push_req(OP_NOP, '1, '1);
        push_req(OP_INIT, '0, '0);
        push_req(OP_ALLOC, 13'd1, '0);
        push_req(OP_ALLOC, 13'd0, '0);
        push_req(OP_ALLOC, 13'd8191, '0);
        push_req(OP_ALLOC, 13'd4094, '0);
        push_req(OP_FREE, '0, frame_va(2));
        push_req(OP_FREE, '0, frame_va(2));
        push_req(OP_FREE, '0, frame_va(4096));
        push_req(OP_FREE, '0, 32'h7FFF_F000);
        push_req(OP_FREE, '0, 32'hFFFF_FFFF);
        push_req(OP_FREE, '0, frame_va(0) + 32'hFFF);
        push_req(OP_ALLOC, 13'd3, '0);
        push_req(OP_ALLOC, 13'd1, '0);
        push_req(OP_FREE, '0, frame_va(3));
        settle();

        // Reserved runs overhanging the map end
        configure(20, 18, 5);
        push_req(OP_INIT, '0, '0);
        push_req(OP_FREE, '0, frame_va(18));
        push_req(OP_ALLOC, 13'd2, '0);
        push_req(OP_FREE, '0, frame_va(0));
        push_req(OP_ALLOC, 13'd18, '0);
        settle();

        // Single-frame map with a zero map-frame count
        write_cfg(CFG_NONE, '1);
        configure(1, 0, 0);
        push_req(OP_INIT, '0, '0);
        push_req(OP_ALLOC, 13'd1, '0);
        push_req(OP_FREE, '0, frame_va(0));
        push_req(OP_ALLOC, 13'd1, '0);
        settle();

        // Random traffic on small maps; one phase holds the sink off for long
        for (p = 0; p < 6; p++) begin
            total = $urandom_range(16, 64);
            configure(total, $urandom_range(0, 8), $urandom_range(0, 3));
            if (p == 2) hold_at = results_seen + 2;
            push_req(OP_INIT, '0, '0);
            repeat (16) pending_reqs.push_back(random_req(total));
            settle();
        end

        // Full-size map, fully reserved at init, no idling from here on
        calm <= 1'b1;
        configure(4096, 4096, 4096);
        push_req(OP_INIT, '0, '0);
        repeat (13) pending_reqs.push_back(random_req(4096));
        settle();

        repeat (20) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            errors++;
        end
        $display("Sent %0d transactions over %0d register settings, checked %0d results.",
                 reqs_sent, settings_used, results_seen);
        $display("Included pre-init requests, clipped reserved runs and a %0d-cycle sink hold.",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/cpfa_pkg.sv
rtl/cpfa_ram.sv
rtl/cpfa_dpath.sv
rtl/cpfa_ctrl.sv
rtl/contiguous_page_frame_allocator.sv
tb/sv/testbench.sv
